@@ src/fir_pkg.sv @@
package fir_pkg;

  // Fixed field widths
  localparam int SAMPLE_W  = 16;
  localparam int FRAC_W    = 15;
  localparam int MODE_W    = 2;
  localparam int TAP_IDX_W = 6;
  localparam int TAPS_W    = 7;
  localparam int PROD_W    = 2 * SAMPLE_W;

  // Request modes
  localparam logic [MODE_W-1:0] MODE_PUSH    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_COEF    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RESTART = 2'd2;

  // Tap count after reset
  localparam logic [TAPS_W-1:0] TAPS_RESET = 7'd64;

  // Saturation limits
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7fff;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

  typedef struct packed {
    logic [MODE_W-1:0]          mode;
    logic [TAP_IDX_W-1:0]       tap_index;
    logic signed [SAMPLE_W-1:0] value;
  } in_req_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] filtered_sample;
    logic                       saturated;
  } out_req_t;

  // Shift controls shared by every cell of the ring
  typedef struct packed {
    logic push;      // new sample enters cell 0, samples move up
    logic samp_rot;  // samples rotate down by one cell
    logic coef_rot;  // coefficients rotate down by one cell
  } cell_ctrl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRE,
    ST_MAC,
    ST_POST,
    ST_FIN,
    ST_SAT
  } seq_state_t;

endpackage

@@ src/fir_filter_stream.sv @@
// Channel | Direction | Handshake           | Payload
// in_     | input     | in_valid / in_stall | in_data   (mode, tap_index, value)
// out_    | output    | out_valid/out_stall | out_data  (filtered_sample, saturated)
// cfg_    | input     | cfg_valid/cfg_ready | cfg_data  (taps_in_use, 7 bits)
//
// Coefficient writes, restarts, unused modes and pushes that give no result
// complete without leaving IDLE. A push that gives a result steps through
// PRE (if needed), MAC, POST (if needed), FIN and SAT: the sample and coefficient rings rotate through
// all MAX_TAPS cells so both return home, one product per cycle at cell 0.
// Reset (rst_n, synchronous) clears coefficients and fill count and sets the tap count to TAPS_RESET.
// A finished result waits in the output register while the next request is
// taken; out_stall only holds the block once a second result is ready.
module fir_filter_stream #(
  parameter int MAX_TAPS = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  fir_pkg::in_req_t                in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output fir_pkg::out_req_t               out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [fir_pkg::TAPS_W-1:0]      cfg_data
);
  import fir_pkg::*;

  localparam int CNT_W = $clog2(MAX_TAPS + 1);
  localparam int ACC_W = PROD_W + $clog2(MAX_TAPS);

  seq_state_t        state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  fill_r, fill_nxt;
  logic [TAPS_W-1:0] taps_r;
  logic [CNT_W-1:0]  n_eff;
  logic [CNT_W-1:0]  rest;
  logic [CNT_W-1:0]  fill_inc;
  logic              in_acc;
  logic              is_push;
  logic              is_coef;
  logic              emit;
  logic              acc_clr;
  logic              out_load;
  logic              out_valid_r;
  out_req_t          out_data_r;
  out_req_t          mac_result;
  cell_ctrl_t        ctrl;

  logic signed [SAMPLE_W-1:0] samp_w [MAX_TAPS];
  logic signed [SAMPLE_W-1:0] coef_w [MAX_TAPS];

  // Configuration register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      taps_r <= TAPS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      taps_r <= cfg_data;
    end
  end

  // Effective tap count, clamped to 1..MAX_TAPS
  always_comb begin
    if (taps_r == '0) begin
      n_eff = CNT_W'(1);
    end else if (32'(taps_r) > 32'(MAX_TAPS)) begin
      n_eff = CNT_W'(MAX_TAPS);
    end else begin
      n_eff = CNT_W'(taps_r);
    end
  end

  assign rest = CNT_W'(MAX_TAPS) - n_eff;

  // Request decode
  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign is_push  = in_acc && (in_data.mode == MODE_PUSH);
  assign is_coef  = in_acc && (in_data.mode == MODE_COEF);
  assign fill_inc = (fill_r == CNT_W'(MAX_TAPS)) ? fill_r : fill_r + CNT_W'(1);
  assign emit     = is_push && (fill_inc >= n_eff);
  assign acc_clr  = emit;

  // Fill count
  always_comb begin
    fill_nxt = fill_r;
    if (in_acc) begin
      unique case (in_data.mode)
        MODE_PUSH:    fill_nxt = fill_inc;
        MODE_RESTART: fill_nxt = '0;
        default:      fill_nxt = fill_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  // Sequencer: PRE aligns coefficients, MAC multiplies, POST restores samples
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    ctrl.push     = 1'b0;
    ctrl.samp_rot = 1'b0;
    ctrl.coef_rot = 1'b0;
    out_load      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        ctrl.push = is_push;
        if (emit) begin
          if (rest != '0) begin
            state_nxt = ST_PRE;
            cnt_nxt   = rest - CNT_W'(1);
          end else begin
            state_nxt = ST_MAC;
            cnt_nxt   = n_eff - CNT_W'(1);
          end
        end
      end
      ST_PRE: begin
        ctrl.coef_rot = 1'b1;
        if (cnt_r == '0) begin
          state_nxt = ST_MAC;
          cnt_nxt   = n_eff - CNT_W'(1);
        end else begin
          cnt_nxt = cnt_r - CNT_W'(1);
        end
      end
      ST_MAC: begin
        ctrl.coef_rot = 1'b1;
        ctrl.samp_rot = 1'b1;
        if (cnt_r == '0) begin
          if (rest != '0) begin
            state_nxt = ST_POST;
            cnt_nxt   = rest - CNT_W'(1);
          end else begin
            state_nxt = ST_FIN;
          end
        end else begin
          cnt_nxt = cnt_r - CNT_W'(1);
        end
      end
      ST_POST: begin
        ctrl.samp_rot = 1'b1;
        if (cnt_r == '0) begin
          state_nxt = ST_FIN;
        end else begin
          cnt_nxt = cnt_r - CNT_W'(1);
        end
      end
      ST_FIN: begin
        state_nxt = ST_SAT;
      end
      ST_SAT: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Ring of cells; coefficients are stored reversed (cell k holds tap MAX_TAPS-1-k)
  for (genvar k = 0; k < MAX_TAPS; k++) begin : g_cell
    localparam int RIDX  = MAX_TAPS - 1 - k;
    localparam int RIGHT = (k + 1) % MAX_TAPS;
    logic                       cell_we;
    logic signed [SAMPLE_W-1:0] left_samp;

    assign cell_we = is_coef && (32'(in_data.tap_index) == 32'(RIDX));

    if (k == 0) begin : g_head
      assign left_samp = in_data.value;
    end else begin : g_body
      assign left_samp = samp_w[k-1];
    end

    fir_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctrl        (ctrl),
      .coef_we     (cell_we),
      .wr_value    (in_data.value),
      .push_in     (left_samp),
      .samp_rot_in (samp_w[RIGHT]),
      .coef_rot_in (coef_w[RIGHT]),
      .sample_out  (samp_w[k]),
      .coef_out    (coef_w[k])
    );
  end

  // Multiply-accumulate on the cell 0 taps
  fir_mac #(
    .ACC_W (ACC_W)
  ) u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .clr    (acc_clr),
    .en     (state_r == ST_MAC),
    .samp   (samp_w[0]),
    .coef   (coef_w[0]),
    .result (mac_result)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= mac_result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Checks
  a_load_from_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (state_r == ST_SAT))
    else $error("result loaded outside the final state");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(MAX_TAPS))
    else $error("fill count beyond ring depth");

  a_mac_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MAC) && (cnt_r != '0) |=> (state_r == ST_MAC))
    else $error("multiply pass ended early");

  a_fin_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN) |-> ($past(state_r) == ST_MAC) || ($past(state_r) == ST_POST))
    else $error("pass finished without multiply or restore");

endmodule

@@ src/fir_cell.sv @@
module fir_cell (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  fir_pkg::cell_ctrl_t                  ctrl,
  input  logic                                 coef_we,
  input  logic signed [fir_pkg::SAMPLE_W-1:0]  wr_value,
  input  logic signed [fir_pkg::SAMPLE_W-1:0]  push_in,
  input  logic signed [fir_pkg::SAMPLE_W-1:0]  samp_rot_in,
  input  logic signed [fir_pkg::SAMPLE_W-1:0]  coef_rot_in,
  output logic signed [fir_pkg::SAMPLE_W-1:0]  sample_out,
  output logic signed [fir_pkg::SAMPLE_W-1:0]  coef_out
);
  import fir_pkg::*;

  logic signed [SAMPLE_W-1:0] sample_r;
  logic signed [SAMPLE_W-1:0] coef_r;

  // Sample slot: shifts up on a push, rotates down during a pass
  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      sample_r <= push_in;
    end else if (ctrl.samp_rot) begin
      sample_r <= samp_rot_in;
    end
  end

  // Coefficient slot: written directly, rotates down during a pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= '0;
    end else begin
      if (coef_we) begin
        coef_r <= wr_value;
      end else if (ctrl.coef_rot) begin
        coef_r <= coef_rot_in;
      end
    end
  end

  assign sample_out = sample_r;
  assign coef_out   = coef_r;

endmodule

@@ src/fir_mac.sv @@
module fir_mac #(
  parameter int ACC_W = 38
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                clr,
  input  logic                                en,
  input  logic signed [fir_pkg::SAMPLE_W-1:0] samp,
  input  logic signed [fir_pkg::SAMPLE_W-1:0] coef,
  output fir_pkg::out_req_t                   result
);
  import fir_pkg::*;

  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W-1:0] prod_nxt;
  logic                     prod_v_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic [ACC_W-FRAC_W-SAMPLE_W:0] hi;
  logic                     fits;

  // Product stage
  assign prod_nxt = samp * coef;

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_v_r <= 1'b0;
    end else begin
      prod_v_r <= en;
    end
  end

  // Accumulate stage
  always_ff @(posedge clk) begin
    if (clr) begin
      acc_r <= '0;
    end else if (prod_v_r) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
  end

  // Floor shift by FRAC_W, then clip: fits when the result's sign bit and all bits above it agree
  assign hi   = acc_r[ACC_W-1:FRAC_W+SAMPLE_W-1];
  assign fits = (&hi) | ~(|hi);

  always_comb begin
    result.saturated = ~fits;
    if (fits) begin
      result.filtered_sample = acc_r[FRAC_W+SAMPLE_W-1:FRAC_W];
    end else if (acc_r[ACC_W-1]) begin
      result.filtered_sample = SAMPLE_MIN;
    end else begin
      result.filtered_sample = SAMPLE_MAX;
    end
  end

endmodule

@@ tb/sv/tb_fir_filter_stream.sv @@
module tb_fir_filter_stream;
  import fir_pkg::*;

  localparam int MAX_TAPS      = 64;
  localparam int SETTLE_CYCLES = 2 * MAX_TAPS + 8;
  localparam int HOLD_CYCLES   = 600;
  localparam int LIMIT_CYCLES  = 1_000_000;
  localparam int STREAM_LEN    = 75;

  // Mode code the block must ignore
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  in_req_t             in_data   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  out_req_t            out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [TAPS_W-1:0]   cfg_data  = '0;

  // Filter state as the block should hold it
  logic signed [SAMPLE_W-1:0] coef_mem   [MAX_TAPS];
  logic signed [SAMPLE_W-1:0] window_mem [MAX_TAPS];
  int                         fill_cnt;
  logic [TAPS_W-1:0]          taps_reg;
  out_req_t                   expected_out_q [$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_armed    = 1'b0;
  int hold_left     = 0;
  int cycle_cnt     = 0;
  int requests_sent = 0;
  int results_seen  = 0;
  int tap_writes    = 0;
  int mismatch_cnt  = 0;

  fir_filter_stream #(.MAX_TAPS(MAX_TAPS)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_cnt,
               expected_out_q.size());
      $display("status: fail");
      $finish;
    end
  end

  // Receiver: random stall, or a long hold-off once armed
  always @(posedge clk) begin
    if (hold_armed) begin
      hold_left  = HOLD_CYCLES;
      hold_armed = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Result checker: every accepted result against the oldest expectation
  always @(posedge clk) begin
    out_req_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (expected_out_q.size() == 0) begin
        $error("unexpected result: filtered_sample %0d saturated %0b",
               out_data.filtered_sample, out_data.saturated);
        mismatch_cnt++;
      end else begin
        want = expected_out_q.pop_front();
        if (out_data.filtered_sample !== want.filtered_sample) begin
          $error("filtered_sample: expected %0d, got %0d",
                 want.filtered_sample, out_data.filtered_sample);
          mismatch_cnt++;
        end
        if (out_data.saturated !== want.saturated) begin
          $error("saturated: expected %0b, got %0b",
                 want.saturated, out_data.saturated);
          mismatch_cnt++;
        end
      end
    end
  end

  // Apply one accepted request to the filter state, queue any result
  task automatic filter_request(input in_req_t r);
    longint    acc;
    longint    q;
    int        n;
    out_req_t  res;
    case (r.mode)
      MODE_COEF:    coef_mem[r.tap_index] = r.value;
      MODE_RESTART: fill_cnt = 0;
      MODE_PUSH: begin
        for (int i = MAX_TAPS - 1; i > 0; i--) window_mem[i] = window_mem[i-1];
        window_mem[0] = r.value;
        if (fill_cnt < MAX_TAPS) fill_cnt++;
        n = (taps_reg < 1) ? 1 : (taps_reg > MAX_TAPS) ? MAX_TAPS : int'(taps_reg);
        if (fill_cnt >= n) begin
          acc = 0;
          // oldest sample of the window meets coefficient 0
          for (int i = 0; i < n; i++)
            acc += longint'(coef_mem[i]) * longint'(window_mem[n-1-i]);
          q = acc >>> FRAC_W;
          res.saturated = 1'b0;
          if (q > longint'(SAMPLE_MAX)) begin
            q = SAMPLE_MAX;
            res.saturated = 1'b1;
          end else if (q < longint'(SAMPLE_MIN)) begin
            q = SAMPLE_MIN;
            res.saturated = 1'b1;
          end
          res.filtered_sample = q[SAMPLE_W-1:0];
          expected_out_q.push_back(res);
        end
      end
      default: ;
    endcase
  endtask

  function automatic in_req_t make_req(input logic [MODE_W-1:0] mode,
                                       input int idx, input int val);
    in_req_t r;
    r.mode      = mode;
    r.tap_index = idx[TAP_IDX_W-1:0];
    r.value     = val[SAMPLE_W-1:0];
    return r;
  endfunction

  function automatic int pick_sample();
    case ($urandom_range(7))
      0:       return SAMPLE_MAX;
      1:       return SAMPLE_MIN;
      2:       return $urandom_range(3) - 2;
      default: return $urandom;
    endcase
  endfunction

  // Half the coefficients small so that not every sum clips
  function automatic int pick_coef();
    if ($urandom_range(1) == 0) return int'($urandom_range(4095)) - 2048;
    return pick_sample();
  endfunction

  // Send one request; valid stays high after acceptance until the next gap
  task automatic send_request(input in_req_t r);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    filter_request(r);
    requests_sent++;
  endtask

  // Stop offering, wait for every result and for the block to go quiet
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_out_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_taps(input int taps);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= taps[TAPS_W-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    taps_reg = taps[TAPS_W-1:0];
    tap_writes++;
  endtask

  // Two taps: field extremes, floor rounding, unused mode, restart, both clips
  task automatic test_modes_and_floor();
    write_taps(2);
    send_request(make_req(MODE_COEF, 0, SAMPLE_MAX));
    send_request(make_req(MODE_COEF, 1, SAMPLE_MIN));
    send_request(make_req(MODE_PUSH, 0, SAMPLE_MAX));
    send_request(make_req(MODE_PUSH, 63, SAMPLE_MIN));
    send_request(make_req(MODE_PUSH, 0, -1));
    send_request(make_req(MODE_UNUSED, 63, -1));
    send_request(make_req(MODE_RESTART, 63, SAMPLE_MAX));
    send_request(make_req(MODE_PUSH, 0, 5));
    send_request(make_req(MODE_PUSH, 0, 7));
    send_request(make_req(MODE_COEF, 1, SAMPLE_MAX));
    send_request(make_req(MODE_PUSH, 0, SAMPLE_MIN));
    send_request(make_req(MODE_PUSH, 0, SAMPLE_MIN));
    send_request(make_req(MODE_COEF, 63, -1));
  endtask

  // Tap count zero acts as one tap: positive clip and negative floor
  task automatic test_single_tap_saturation();
    write_taps(0);
    send_request(make_req(MODE_COEF, 0, SAMPLE_MIN));
    send_request(make_req(MODE_PUSH, 0, SAMPLE_MIN));
    send_request(make_req(MODE_PUSH, 0, SAMPLE_MAX));
    send_request(make_req(MODE_COEF, 0, 1));
    send_request(make_req(MODE_PUSH, 0, -1));
    send_request(make_req(MODE_PUSH, 0, 0));
  endtask

  // Coefficient burst, then mostly pushes with some writes, restarts, noise
  task automatic run_stream(input int taps);
    int     sel;
    in_req_t r;
    write_taps(taps);
    for (int k = 0; k < STREAM_LEN; k++) begin
      sel = $urandom_range(99);
      r   = make_req(MODE_PUSH, $urandom_range(63), pick_sample());
      if (k < STREAM_LEN / 6 || (sel >= 82 && sel < 96)) begin
        r.mode  = MODE_COEF;
        r.value = pick_coef();
      end else if (sel == 96) begin
        r.mode = MODE_RESTART;
      end else if (sel > 96) begin
        r.mode = MODE_UNUSED;
      end
      send_request(r);
    end
  endtask

  task automatic test_random_traffic();
    send_idle_pct = 16;
    recv_idle_pct = 85;
    run_stream(127);
    run_stream($urandom_range(2, 63));
    send_idle_pct = 85;
    recv_idle_pct = 16;
    run_stream(64);
    run_stream(1);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_stream($urandom_range(127));
    run_stream(3);
  endtask

  // Long receiver hold-off while pushes keep coming, so the input stalls
  task automatic test_output_backpressure();
    write_taps(1);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_armed    = 1'b1;
    repeat (12) send_request(make_req(MODE_PUSH, $urandom_range(63), pick_sample()));
  endtask

  initial begin
    foreach (coef_mem[i]) coef_mem[i] = '0;
    foreach (window_mem[i]) window_mem[i] = '0;
    fill_cnt = 0;
    taps_reg = TAPS_RESET;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_modes_and_floor();
    test_single_tap_saturation();
    test_random_traffic();
    test_output_backpressure();
    wait_idle();

    $display("covered %0d requests over %0d tap-count writes; %0d results checked",
             requests_sent, tap_writes, results_seen);
    if (mismatch_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/fir_pkg.sv
src/fir_cell.sv
src/fir_mac.sv
src/fir_filter_stream.sv
tb/sv/tb_fir_filter_stream.sv
